// ===== hw/rtl/bsd_pkg.sv =====
`timescale 1ns / 1ps
package bsd_pkg;
  localparam int unsigned WGT_BITS = 17;
  localparam logic [WGT_BITS-1:0] WGT_ONE = 17'h10000;
  localparam logic [WGT_BITS-1:0] WGT_RESET = 17'h08000;
  localparam int unsigned LVL_BITS = 3;
  localparam int unsigned OUT_BITS = 32;
  typedef logic [LVL_BITS-1:0] lvl_t;
  typedef logic [WGT_BITS-1:0] wgt_t;
endpackage

// ===== hw/rtl/bsd_if.sv =====
`timescale 1ns / 1ps
interface bsd_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
  logic [2:0] levels;
  modport source (output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  levels, input ready);
  modport sink (input valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                levels, output ready);
endinterface

interface bsd_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] q0_x, q0_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y;
  logic last_piece;
  modport source (output valid, q0_x, q0_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y,
                  last_piece, input ready);
  modport sink (input valid, q0_x, q0_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y,
                last_piece, output ready);
endinterface

// ===== hw/rtl/bsd_ram.sv =====
`timescale 1ns / 1ps
module bsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/bezier_subdivider_unit.sv =====
`timescale 1ns / 1ps
// channel | dir | payload                          | handshake
// in_     | in  | p0..p3 x/y, levels               | valid/ready
// out_    | out | q0..q3 x/y, last_piece           | valid/ready
// cfg_    | in  | split_weight (17 b)              | write enable
// one curve at a time; a split runs x then y through one shared multiply pair:
// 7 steps a lane (6 mixes, then the write-back).
// a pop reloads a pending half from the ram (one word per cycle).
// per curve: an accept, 2^L-1 splits, 2^L-1 pops and an emit and a wait for each leaf.
// reset is synchronous, the ram needs no clear.
// the output register holds a leaf while out_ready is low; the walk waits only at the next leaf.
module bezier_subdivider_unit import bsd_pkg::*; #(
  parameter int MAX_LEVELS = 6,
  parameter int COORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  bsd_in_if.sink     in_ch,
  bsd_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [WGT_BITS-1:0] cfg_wdata
);
  localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int DEPTH = MAX_LEVELS * 8;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(MAX_LEVELS + 1);
  localparam int PW = CW + WGT_BITS + 2;

  localparam logic [2:0] S_IDLE = 3'd0, S_SPLIT = 3'd1, S_EMIT = 3'd2,
                         S_WAIT = 3'd3, S_POP = 3'd4;

  logic [2:0] st_r, st_nxt;
  wgt_t wgt_r;
  lvl_t lvl_r;
  lvl_t depth_r;
  logic [SW-1:0] sp_r;
  logic [LVL_BITS-1:0] pdep_r [MAX_LEVELS];
  logic signed [CW-1:0] cur_r [8];
  logic signed [CW-1:0] tmp_r [6];
  logic [2:0] cnt_r;
  logic [1:0] lane_r;
  logic [3:0] pcnt_r;

  // ram
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata, ram_rdata;
  bsd_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  wgt_t w_eff;
  assign w_eff = (wgt_r > WGT_ONE) ? WGT_ONE : wgt_r;

  // mix unit: operands by step
  logic signed [CW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [CW-1:0] mres;
  logic [1:0] k;
  assign k = lane_r;
  always_comb begin
    unique case (cnt_r)
      3'd0: begin ma = cur_r[{2'b00, k[0]}];       mb = cur_r[{2'b01, k[0]}]; end
      3'd1: begin ma = cur_r[{2'b01, k[0]}];       mb = cur_r[{2'b10, k[0]}]; end
      3'd2: begin ma = cur_r[{2'b10, k[0]}];       mb = cur_r[{2'b11, k[0]}]; end
      3'd3: begin ma = tmp_r[0];                   mb = tmp_r[1]; end
      3'd4: begin ma = tmp_r[1];                   mb = tmp_r[2]; end
      3'd5: begin ma = tmp_r[3];                   mb = tmp_r[4]; end
      default: begin ma = tmp_r[3]; mb = tmp_r[4]; end
    endcase
    prod = PW'(ma) * $signed({1'b0, w_eff}) +
           PW'(mb) * $signed({1'b0, WGT_ONE - w_eff});
    mres = CW'(prod >>> 16);
  end

  logic push_base;
  assign push_base = 1'b1;
  logic [AW-1:0] wbase, rbase;
  assign wbase = AW'(sp_r) * AW'(8);
  assign rbase = AW'(sp_r - SW'(1)) * AW'(8);

  logic out_v_r, out_last_r;
  logic signed [CW-1:0] out_q_r [8];

  function automatic logic signed [CW-1:0] cin(input logic [31:0] v);
    return v[CW-1:0];
  endfunction

  always_comb begin
    st_nxt = st_r;
    ram_we = 1'b0;
    ram_waddr = wbase + AW'({cnt_r[1:0], k[0]});
    ram_wdata = '0;
    ram_raddr = rbase + AW'(pcnt_r[2:0]);
    unique case (st_r)
      S_IDLE: if (in_ch.valid) st_nxt = (in_ch.levels == 3'd0) ? S_EMIT : S_SPLIT;
      S_SPLIT: begin
        if (cnt_r == 3'd5) begin
          ram_we = push_base;
          ram_waddr = wbase + AW'({2'b00, k[0]});
          ram_wdata = mres;
        end else if (cnt_r == 3'd4) begin
          ram_we = 1'b1;
          ram_waddr = wbase + AW'({2'b01, k[0]});
          ram_wdata = mres;
        end else if (cnt_r == 3'd2) begin
          ram_we = 1'b1;
          ram_waddr = wbase + AW'({2'b10, k[0]});
          ram_wdata = mres;
        end else if (cnt_r == 3'd6) begin
          ram_we = 1'b1;
          ram_waddr = wbase + AW'({2'b11, k[0]});
          ram_wdata = cur_r[{2'b11, k[0]}];
        end
        if (cnt_r == 3'd6 && k[0] && (depth_r + 3'd1 >= lvl_r)) st_nxt = S_EMIT;
      end
      S_EMIT: if (!out_v_r || out_ch.ready) st_nxt = S_WAIT;
      S_WAIT: st_nxt = (sp_r == '0) ? S_IDLE : S_POP;
      S_POP: if (pcnt_r == 4'd8)
        st_nxt = (pdep_r[sp_r - SW'(1)] >= lvl_r) ? S_EMIT : S_SPLIT;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      wgt_r <= WGT_RESET;
      sp_r <= '0;
      cnt_r <= '0;
      lane_r <= '0;
      pcnt_r <= '0;
      depth_r <= '0;
      lvl_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) wgt_r <= cfg_wdata;
      if (st_r == S_EMIT && (!out_v_r || out_ch.ready)) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_ch.valid) begin
          lvl_r <= (in_ch.levels > LVL_BITS'(MAX_LEVELS)) ? LVL_BITS'(MAX_LEVELS)
                                                         : in_ch.levels;
          depth_r <= '0;
          sp_r <= '0;
          cnt_r <= '0;
          lane_r <= '0;
        end
        S_SPLIT: begin
          if (cnt_r <= 3'd5) tmp_r[cnt_r] <= mres;
          if (cnt_r == 3'd6) begin
            cur_r[{2'b01, k[0]}] <= tmp_r[0];
            cur_r[{2'b10, k[0]}] <= tmp_r[3];
            cur_r[{2'b11, k[0]}] <= tmp_r[5];
            cnt_r <= '0;
            if (k[0]) begin
              lane_r <= '0;
              pdep_r[sp_r] <= depth_r + 3'd1;
              sp_r <= sp_r + SW'(1);
              depth_r <= depth_r + 3'd1;
            end else begin
              lane_r <= 2'd1;
            end
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_EMIT: if (!out_v_r || out_ch.ready) begin
          out_q_r <= cur_r;
          out_last_r <= (sp_r == '0);
          pcnt_r <= '0;
        end
        S_WAIT: pcnt_r <= '0;
        S_POP: begin
          if (pcnt_r != 4'd0) cur_r[pcnt_r[2:0] - 3'd1] <= ram_rdata;
          if (pcnt_r == 4'd8) begin
            sp_r <= sp_r - SW'(1);
            depth_r <= pdep_r[sp_r - SW'(1)];
            cnt_r <= '0;
            lane_r <= '0;
          end else begin
            pcnt_r <= pcnt_r + 4'd1;
          end
        end
        default: ;
      endcase
      if (st_r == S_IDLE && in_ch.valid) begin
        cur_r[0] <= cin(in_ch.p0_x); cur_r[1] <= cin(in_ch.p0_y);
        cur_r[2] <= cin(in_ch.p1_x); cur_r[3] <= cin(in_ch.p1_y);
        cur_r[4] <= cin(in_ch.p2_x); cur_r[5] <= cin(in_ch.p2_y);
        cur_r[6] <= cin(in_ch.p3_x); cur_r[7] <= cin(in_ch.p3_y);
      end
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.last_piece = out_last_r;
  assign out_ch.q0_x = OUT_BITS'(out_q_r[0]);
  assign out_ch.q0_y = OUT_BITS'(out_q_r[1]);
  assign out_ch.q1_x = OUT_BITS'(out_q_r[2]);
  assign out_ch.q1_y = OUT_BITS'(out_q_r[3]);
  assign out_ch.q2_x = OUT_BITS'(out_q_r[4]);
  assign out_ch.q2_y = OUT_BITS'(out_q_r[5]);
  assign out_ch.q3_x = OUT_BITS'(out_q_r[6]);
  assign out_ch.q3_y = OUT_BITS'(out_q_r[7]);

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SW'(MAX_LEVELS)) else $error("stack overflow");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !ram_we) else $error("ram write while idle");
  a_last_stack: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT && st_nxt == S_WAIT) |=> (out_last_r == (sp_r == '0)))
    else $error("last flag mismatch");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_POP) |-> (sp_r != '0)) else $error("pop of empty stack");
endmodule
